[src/sil_pkg.sv]
package sil_pkg;

    // Result field widths
    localparam int EFF_OUT_W  = 27;
    localparam int DEV_OUT_W  = 25;
    localparam int J2_OUT_W   = 51;
    localparam int ROOT_OUT_W = 26;
    localparam int LODE_W     = 26;

    // Q1.30 scaling
    localparam int          Q30_FRAC      = 30;
    localparam logic [30:0] Q30_SQRT2     = 31'd1518500250;
    localparam logic [30:0] Q30_INV_SQRT3 = 31'd619925131;

    // Fields known before the square root
    typedef struct packed {
        logic signed [EFF_OUT_W-1:0] eff;
        logic signed [DEV_OUT_W-1:0] dev_xx;
        logic signed [DEV_OUT_W-1:0] dev_yy;
        logic signed [DEV_OUT_W-1:0] dev_zz;
        logic        [J2_OUT_W-1:0]  j2;
        logic signed [LODE_W-1:0]    axial;
    } t_payload;

    typedef struct packed {
        t_payload                pay;
        logic [ROOT_OUT_W-1:0]   root;
        logic [LODE_W-1:0]       radius;
    } t_result;

    localparam int OUT_RAW_W  = EFF_OUT_W + 3 * DEV_OUT_W + J2_OUT_W + ROOT_OUT_W + 2 * LODE_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

endpackage

[src/sil_front.sv]
module sil_front import sil_pkg::*; #(
    parameter int STRESS_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [STRESS_BITS-1:0] i_stress [9],
    input  logic        [STRESS_BITS-2:0] i_pore,
    output logic                          o_vld,
    output t_payload                      o_pay
);

    localparam int SB     = STRESS_BITS;
    localparam int TR_W   = SB + 2;
    localparam int UW     = SB + 3;
    localparam int P3_W   = SB + 1;
    localparam int EFF_W  = SB + 3;
    localparam int DEV_W  = SB + 1;
    localparam int OSQ_W  = 2 * SB - 1;
    localparam int DSQ_W  = 2 * SB + 1;
    localparam int SUM_W  = 2 * SB + 3;
    localparam int AXP_W  = EFF_W + 32;
    localparam int NSTG   = 6;

    // floor(x/3) via offset to non-negative and reciprocal multiply
    localparam logic [UW-1:0]          DIV3_M   = UW'(((64'd1 << (UW + 1)) + 64'd2) / 64'd3);
    localparam logic [UW-1:0]          U_OFS    = UW'(64'd3 << SB);
    localparam logic signed [TR_W-1:0] MEAN_OFS = TR_W'(64'd1 << SB);
    localparam logic signed [AXP_W-1:0] AX_HALF = AXP_W'(64'd1 << (Q30_FRAC - 1));

    localparam int OFF_IDX [6]  = '{1, 2, 3, 5, 6, 7};
    localparam int DIAG_IDX [3] = '{0, 4, 8};

    logic [NSTG-1:0] r_vld;

    // stage A
    logic signed [TR_W-1:0]  r_a_tr;
    logic        [UW-1:0]    r_a_u;
    logic        [P3_W-1:0]  r_a_p3;
    logic signed [SB-1:0]    r_a_d [3];
    logic        [OSQ_W-1:0] r_a_osq [6];
    logic signed [2*SB-1:0]  w_osq [6];
    // stage B
    logic [2*UW-1:0]         r_b_prod;
    logic signed [EFF_W-1:0] r_b_eff;
    logic signed [SB-1:0]    r_b_d [3];
    logic [OSQ_W:0]          r_b_op [3];
    // stage C
    logic signed [TR_W-1:0]  w_mean;
    logic signed [DEV_W-1:0] r_c_dev [3];
    logic [OSQ_W+1:0]        r_c_os;
    logic signed [EFF_W-1:0] r_c_eff;
    // stage D
    logic signed [2*DEV_W-1:0] w_dsq [3];
    logic [DSQ_W-1:0]          r_d_dsq [3];
    logic signed [AXP_W-1:0]   r_d_axp;
    logic [OSQ_W+1:0]          r_d_os;
    logic signed [DEV_W-1:0]   r_d_dev [3];
    logic signed [EFF_W-1:0]   r_d_eff;
    // stage E
    logic signed [AXP_W-1:0]   w_axr;
    logic [SUM_W-1:0]          r_e_s0;
    logic [SUM_W-1:0]          r_e_s1;
    logic signed [LODE_W-1:0]  r_e_ax;
    logic signed [DEV_W-1:0]   r_e_dev [3];
    logic signed [EFF_W-1:0]   r_e_eff;
    // stage F
    logic [SUM_W-1:0]          w_sum;
    t_payload                  r_f_pay;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_osq[k] = i_stress[OFF_IDX[k]] * i_stress[OFF_IDX[k]];
        end
        for (int k = 0; k < 3; k++) begin
            w_dsq[k] = r_c_dev[k] * r_c_dev[k];
        end
        w_mean = signed'(r_b_prod[2*UW-1:UW+1]) - MEAN_OFS;
        w_axr  = r_d_axp + AX_HALF;
        w_sum  = r_e_s0 + r_e_s1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // A: trace, offset trace, 3*pore, off-diagonal squares
            r_a_tr <= TR_W'(i_stress[0]) + TR_W'(i_stress[4]) + TR_W'(i_stress[8]);
            r_a_u  <= UW'(i_stress[0]) + UW'(i_stress[4]) + UW'(i_stress[8]) + U_OFS;
            r_a_p3 <= P3_W'(i_pore) + (P3_W'(i_pore) << 1);
            for (int k = 0; k < 3; k++) begin
                r_a_d[k] <= i_stress[DIAG_IDX[k]];
            end
            for (int k = 0; k < 6; k++) begin
                r_a_osq[k] <= w_osq[k][OSQ_W-1:0];
            end

            // B: reciprocal multiply, effective trace, pair sums
            r_b_prod <= r_a_u * DIV3_M;
            r_b_eff  <= EFF_W'(r_a_tr) + EFF_W'(r_a_p3);
            r_b_d    <= r_a_d;
            for (int k = 0; k < 3; k++) begin
                r_b_op[k] <= (OSQ_W + 1)'(r_a_osq[2*k]) + (OSQ_W + 1)'(r_a_osq[2*k+1]);
            end

            // C: deviatoric diagonal, off-diagonal square sum
            for (int k = 0; k < 3; k++) begin
                r_c_dev[k] <= DEV_W'(TR_W'(r_b_d[k]) - w_mean);
            end
            r_c_os  <= (OSQ_W + 2)'(r_b_op[0]) + (OSQ_W + 2)'(r_b_op[1])
                     + (OSQ_W + 2)'(r_b_op[2]);
            r_c_eff <= r_b_eff;

            // D: deviatoric squares, axial product
            for (int k = 0; k < 3; k++) begin
                r_d_dsq[k] <= w_dsq[k][DSQ_W-1:0];
            end
            r_d_axp <= r_c_eff * signed'({1'b0, Q30_INV_SQRT3});
            r_d_os  <= r_c_os;
            r_d_dev <= r_c_dev;
            r_d_eff <= r_c_eff;

            // E: partial sums, axial rounding (ties toward +inf)
            r_e_s0  <= SUM_W'(r_d_dsq[0]) + SUM_W'(r_d_dsq[1]);
            r_e_s1  <= SUM_W'(r_d_dsq[2]) + SUM_W'(r_d_os);
            r_e_ax  <= LODE_W'(w_axr >>> Q30_FRAC);
            r_e_dev <= r_d_dev;
            r_e_eff <= r_d_eff;

            // F: J2
            r_f_pay.j2     <= J2_OUT_W'(w_sum >> 1);
            r_f_pay.eff    <= EFF_OUT_W'(r_e_eff);
            r_f_pay.dev_xx <= DEV_OUT_W'(r_e_dev[0]);
            r_f_pay.dev_yy <= DEV_OUT_W'(r_e_dev[1]);
            r_f_pay.dev_zz <= DEV_OUT_W'(r_e_dev[2]);
            r_f_pay.axial  <= r_e_ax;
        end
    end

    assign o_vld = r_vld[NSTG-1];
    assign o_pay = r_f_pay;

endmodule

[src/sil_isqrt.sv]
module sil_isqrt import sil_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  t_payload              i_pay,
    output logic                  o_vld,
    output t_payload              o_pay,
    output logic [ROOT_OUT_W-1:0] o_root
);

    localparam int RT_W  = ROOT_OUT_W;
    localparam int N_W   = 2 * RT_W;
    localparam int REM_W = RT_W + 3;

    // one root bit per stage, radicand shifted up two bits per stage
    logic [REM_W-1:0] w_rem  [RT_W];
    logic [N_W-1:0]   w_rad  [RT_W];
    logic [RT_W-1:0]  w_root [RT_W+1];
    t_payload         w_pay  [RT_W+1];
    logic [RT_W:0]    w_vld;

    assign w_rem[0]  = '0;
    assign w_rad[0]  = N_W'(i_pay.j2);
    assign w_root[0] = '0;
    assign w_pay[0]  = i_pay;
    assign w_vld[0]  = i_vld;

    for (genvar g = 0; g < RT_W; g++) begin : g_stage
        logic [REM_W-1:0] w_sh;
        logic [REM_W-1:0] w_trial;
        logic             w_ge;
        logic             r_vld;
        logic [RT_W-1:0]  r_root;
        t_payload         r_pay;

        assign w_sh    = {w_rem[g][REM_W-3:0], w_rad[g][N_W-1 -: 2]};
        assign w_trial = REM_W'({w_root[g], 2'b01});
        assign w_ge    = (w_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root <= {w_root[g][RT_W-2:0], w_ge};
                r_pay  <= w_pay[g];
            end
        end

        assign w_vld[g+1]  = r_vld;
        assign w_root[g+1] = r_root;
        assign w_pay[g+1]  = r_pay;

        if (g < RT_W - 1) begin : g_carry
            logic [REM_W-1:0] r_rem;
            logic [N_W-1:0]   r_rad;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= w_ge ? (w_sh - w_trial) : w_sh;
                    r_rad <= w_rad[g] << 2;
                end
            end

            assign w_rem[g+1] = r_rem;
            assign w_rad[g+1] = r_rad;
        end
    end

    assign o_vld  = w_vld[RT_W];
    assign o_pay  = w_pay[RT_W];
    assign o_root = w_root[RT_W];

endmodule

[src/sil_radius.sv]
module sil_radius import sil_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  t_payload              i_pay,
    input  logic [ROOT_OUT_W-1:0] i_root,
    output logic                  o_vld,
    output t_result               o_res
);

    localparam int PR_W = ROOT_OUT_W + 32;
    localparam logic [PR_W-1:0] RND_HALF = PR_W'(64'd1 << (Q30_FRAC - 1));

    logic [1:0]            r_vld;
    logic [PR_W-1:0]       r_prod;
    logic [PR_W-1:0]       w_rnd;
    logic [ROOT_OUT_W-1:0] r_root;
    t_payload              r_pay;
    t_result               r_res;

    assign w_rnd = r_prod + RND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PR_W'(i_root) * PR_W'(Q30_SQRT2);
            r_root <= i_root;
            r_pay  <= i_pay;

            r_res.pay    <= r_pay;
            r_res.root   <= r_root;
            r_res.radius <= LODE_W'(w_rnd >> Q30_FRAC);
        end
    end

    assign o_vld = r_vld[1];
    assign o_res = r_res;

endmodule

[src/stress_invariants_lode.sv]
// Path from an accepted request to m_axis: front stages, square-root pipeline, radius stages, output register.
// Throughput: one tensor per cycle while s_axis_tready is high; the 26-stage square-root pipeline sets the depth.
// Back-pressure: the output register plus a one-entry skid buffer; s_axis_tready
// drops only while the skid buffer is occupied, and the whole pipeline holds then.
// Reset: synchronous, active low; clears valid flags only, data registers are not reset.
module stress_invariants_lode import sil_pkg::*; #(
    parameter int STRESS_BITS = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // stress_xx, xy, xz, yx, yy, yz, zx, zy, zz, pore_pressure
    input  logic [((10*STRESS_BITS+6)/8)*8-1:0]       s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // first_invariant_eff, dev_xx, dev_yy, dev_zz, second_invariant,
    // root_second_invariant, lode_radius, lode_axial
    output logic [OUT_DATA_W-1:0]                     m_axis_tdata
);

    logic signed [STRESS_BITS-1:0] w_stress [9];
    logic [STRESS_BITS-2:0]        w_pore;
    logic                          w_en;

    logic                  w_f_vld;
    t_payload              w_f_pay;
    logic                  w_q_vld;
    t_payload              w_q_pay;
    logic [ROOT_OUT_W-1:0] w_q_root;
    logic                  w_p_vld;
    t_result               w_p_res;

    logic    w_take;
    logic    r_out_vld;
    t_result r_out;
    logic    r_skid_vld;
    t_result r_skid;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_stress[k] = s_axis_tdata[k*STRESS_BITS +: STRESS_BITS];
        end
    end
    assign w_pore = s_axis_tdata[9*STRESS_BITS +: STRESS_BITS-1];

    // pipeline advances whenever the skid buffer is empty
    assign w_en          = !r_skid_vld;
    assign s_axis_tready = w_en;

    sil_front #(
        .STRESS_BITS (STRESS_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (s_axis_tvalid),
        .i_stress (w_stress),
        .i_pore   (w_pore),
        .o_vld    (w_f_vld),
        .o_pay    (w_f_pay)
    );

    sil_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_pay   (w_f_pay),
        .o_vld   (w_q_vld),
        .o_pay   (w_q_pay),
        .o_root  (w_q_root)
    );

    sil_radius u_radius (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_q_vld),
        .i_pay   (w_q_pay),
        .i_root  (w_q_root),
        .o_vld   (w_p_vld),
        .o_res   (w_p_res)
    );

    assign w_take = r_out_vld && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            priority if (r_skid_vld) begin
                if (w_take) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (w_p_vld) begin
                if (r_out_vld && !w_take) begin
                    r_skid_vld <= 1'b1;
                end else begin
                    r_out_vld <= 1'b1;
                end
            end else if (w_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_skid_vld) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_p_vld) begin
            if (r_out_vld && !w_take) begin
                r_skid <= w_p_res;
            end else begin
                r_out <= w_p_res;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_DATA_W'({r_out.pay.axial, r_out.radius, r_out.root,
                                        r_out.pay.j2, r_out.pay.dev_zz, r_out.pay.dev_yy,
                                        r_out.pay.dev_xx, r_out.pay.eff});

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held without an output entry");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !m_axis_tready))
        else $error("skid filled while output was free");

    a_root_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (64'(r_out.root) * 64'(r_out.root) <= 64'(r_out.pay.j2)))
        else $error("square root too large");

    a_root_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((64'(r_out.root) + 64'd1) * (64'(r_out.root) + 64'd1)
                       > 64'(r_out.pay.j2)))
        else $error("square root too small");
`endif

endmodule
